// ----- rtl/gregorian_date_difference_macros.svh -----
// Assertion macros for the Gregorian date difference block.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef GREGORIAN_DATE_DIFFERENCE_MACROS_SVH
`define GREGORIAN_DATE_DIFFERENCE_MACROS_SVH

`ifndef SYNTHESIS
// check that holds outside reset
`define GDD_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("gregorian_date_difference: check failed");
// check that also holds while reset is applied
`define GDD_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("gregorian_date_difference: check failed");
`else
`define GDD_ASSERT(label, clk, rst_n, prop)
`define GDD_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

// ----- rtl/gdd_pkg.sv -----
// Shared types, constants and the month table for the date difference block.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package gdd_pkg;

    localparam int YEAR_W  = 14;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int ORD_W   = 23;   // ordinal day number, unsigned
    localparam int DIFF_W  = 23;   // signed day difference
    localparam int DOY_W   = 10;   // day of year including overflowing days
    localparam int DBM_W   = 9;    // days before month
    localparam int LEAPS_W = 13;   // leap days before a year

    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 24;

    // x / 100 == (x * DIV100_MUL) >> DIV100_SHIFT, exact for x < 43690
    localparam logic [12:0] DIV100_MUL   = 13'd5243;
    localparam int          DIV100_SHIFT = 19;

    localparam logic [4:0] MONTH_JAN = 5'd1;
    localparam logic [3:0] MONTH_FEB = 4'd2;

    localparam logic signed [DIFF_W:0] DIFF_SAT_POS = 24'sd4194303;
    localparam logic signed [DIFF_W:0] DIFF_SAT_NEG = -24'sd4194303;

    // per-stage load enables of the lane pipeline
    typedef struct packed {
        logic s1_en;
        logic s2_en;
        logic s3_en;
    } t_lane_ctl;

    // days before the first of a month; month zero reads as January,
    // months above twelve read as December
    function automatic logic [DBM_W-1:0] days_before_month(input logic [MONTH_W-1:0] m);
        logic [DBM_W-1:0] v;
        unique case (m)
            4'd0, 4'd1: v = 9'd0;
            4'd2:       v = 9'd31;
            4'd3:       v = 9'd59;
            4'd4:       v = 9'd90;
            4'd5:       v = 9'd120;
            4'd6:       v = 9'd151;
            4'd7:       v = 9'd181;
            4'd8:       v = 9'd212;
            4'd9:       v = 9'd243;
            4'd10:      v = 9'd273;
            4'd11:      v = 9'd304;
            default:    v = 9'd334;
        endcase
        return v;
    endfunction

endpackage

// ----- rtl/gdd_lane.sv -----
// One date lane: turns a year, month and day into an ordinal day number.
// Three register stages; depends on gdd_pkg.
`timescale 1ns / 1ps

module gdd_lane (
    input  logic                         i_clk,
    input  gdd_pkg::t_lane_ctl           i_ctl,
    input  logic [gdd_pkg::YEAR_W-1:0]   i_year,
    input  logic [gdd_pkg::MONTH_W-1:0]  i_month,
    input  logic [gdd_pkg::DAY_W-1:0]    i_day,
    output logic [gdd_pkg::ORD_W-1:0]    o_ordinal
);
    import gdd_pkg::*;

    // stage 1 registers
    logic [ORD_W-1:0]   r_y365;
    logic [26:0]        r_p100;
    logic [27:0]        r_p99;
    logic [25:0]        r_p399;
    logic [12:0]        r_q4;
    logic [YEAR_W-1:0]  r_year;
    logic [DBM_W-1:0]   r_dbm;
    logic               r_feb_past;
    logic [DAY_W-1:0]   r_day;
    // stage 2 registers
    logic [ORD_W-1:0]   r_y365_b;
    logic [LEAPS_W-1:0] r_leaps;
    logic [DOY_W-1:0]   r_doy;
    // stage 3 register
    logic [ORD_W-1:0]   r_ord;

    logic [14:0]        n_y99;
    logic [14:0]        n_y399;
    logic [7:0]         n_q100;
    logic [8:0]         n_q99;
    logic [6:0]         n_q400;
    logic               n_leap;
    logic [LEAPS_W-1:0] n_leaps;
    logic [DOY_W-1:0]   n_doy;

    assign n_y99  = {1'b0, i_year} + 15'd99;
    assign n_y399 = {1'b0, i_year} + 15'd399;

    // stage 1: constant multiplications for year days and the divisions
    always_ff @(posedge i_clk) begin
        if (i_ctl.s1_en) begin
            r_y365     <= {9'd0, i_year} * 23'd365;
            r_p100     <= {13'd0, i_year} * {14'd0, DIV100_MUL};
            r_p99      <= {13'd0, n_y99} * {15'd0, DIV100_MUL};
            r_p399     <= {13'd0, n_y399[14:2]} * {13'd0, DIV100_MUL};
            r_q4       <= 13'(({1'b0, i_year} + 15'd3) >> 2);
            r_year     <= i_year;
            r_dbm      <= days_before_month(i_month);
            r_feb_past <= (i_month > MONTH_FEB);
            r_day      <= i_day;
        end
    end

    // stage 2: quotients, leap test, leap days before the year, day of year
    assign n_q100 = r_p100[DIV100_SHIFT +: 8];
    assign n_q99  = r_p99[DIV100_SHIFT +: 9];
    assign n_q400 = r_p399[DIV100_SHIFT +: 7];
    assign n_leap = (r_year[1:0] == 2'd0)
                 && (({6'd0, n_q100} * 14'd100 != r_year) || (n_q100[1:0] == 2'd0));
    assign n_leaps = r_q4 - {4'd0, n_q99} + {6'd0, n_q400};
    assign n_doy   = {1'b0, r_dbm} + {5'd0, r_day} + {9'd0, n_leap && r_feb_past};

    always_ff @(posedge i_clk) begin
        if (i_ctl.s2_en) begin
            r_y365_b <= r_y365;
            r_leaps  <= n_leaps;
            r_doy    <= n_doy;
        end
    end

    // stage 3: ordinal sum
    always_ff @(posedge i_clk) begin
        if (i_ctl.s3_en) begin
            r_ord <= r_y365_b + {10'd0, r_leaps} + {13'd0, r_doy};
        end
    end

    assign o_ordinal = r_ord;

endmodule

// ----- rtl/gdd_merge.sv -----
// Merge stage: subtracts the two lane ordinals and saturates to 23 bits.
// One register stage; depends on gdd_pkg.
`timescale 1ns / 1ps

module gdd_merge (
    input  logic                       i_clk,
    input  logic                       i_en,
    input  logic [gdd_pkg::ORD_W-1:0]  i_ord_first,
    input  logic [gdd_pkg::ORD_W-1:0]  i_ord_second,
    output logic [gdd_pkg::DIFF_W-1:0] o_diff
);
    import gdd_pkg::*;

    logic signed [DIFF_W:0] n_raw;
    logic signed [DIFF_W:0] n_sat;
    logic [DIFF_W-1:0]      r_diff;

    // wide signed difference, then clamp to the symmetric output range
    assign n_raw = $signed({1'b0, i_ord_second}) - $signed({1'b0, i_ord_first});

    always_comb begin
        priority if (n_raw > DIFF_SAT_POS) begin
            n_sat = DIFF_SAT_POS;
        end else if (n_raw < DIFF_SAT_NEG) begin
            n_sat = DIFF_SAT_NEG;
        end else begin
            n_sat = n_raw;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_diff <= n_sat[DIFF_W-1:0];
        end
    end

    assign o_diff = r_diff;

endmodule

// ----- rtl/gregorian_date_difference.sv -----
// Top level: two date lanes, merge stage and the stream handshake control.
// Depends on gdd_pkg, gdd_lane, gdd_merge and the assertion macro header.
//
//  channel | dir | fields (low bit first)
//  --------+-----+--------------------------------------------------------------
//  s       | in  | first_year, first_month, first_day, second_year,
//          |     | second_month, second_day (46 bits, zero pad to 48)
//  m       | out | day_difference (23 bits signed, zero pad to 24)
//
// One item per cycle sustained while the output is not stalled; each item passes three lane stages
// and one merge stage, the two dates are handled by separate lanes in parallel.
// Reset (i_rst_n low, synchronous) empties all stage valid bits.
// A stalled output only holds the stages that are full; bubbles close up,
// so input stays ready while any stage is free.
`timescale 1ns / 1ps

`include "gregorian_date_difference_macros.svh"

module gregorian_date_difference (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    // first_year[13:0], first_month[17:14], first_day[22:18],
    // second_year[36:23], second_month[40:37], second_day[45:41], zero[47:46]
    input  logic [gdd_pkg::IN_TDATA_W-1:0]     i_s_tdata,
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    // day_difference[22:0], zero[23]
    output logic [gdd_pkg::OUT_TDATA_W-1:0]    o_m_tdata
);
    import gdd_pkg::*;

    logic             r_v1, r_v2, r_v3, r_v4;
    logic             n_en1, n_en2, n_en3, n_en4;
    t_lane_ctl        n_ctl;
    logic [ORD_W-1:0] w_ord_first;
    logic [ORD_W-1:0] w_ord_second;
    logic [DIFF_W-1:0] w_diff;

    // a stage loads when it is empty or its contents move on
    assign n_en4 = !r_v4 || i_m_tready;
    assign n_en3 = !r_v3 || n_en4;
    assign n_en2 = !r_v2 || n_en3;
    assign n_en1 = !r_v1 || n_en2;

    assign n_ctl.s1_en = n_en1;
    assign n_ctl.s2_en = n_en2;
    assign n_ctl.s3_en = n_en3;

    // stage valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (n_en1) r_v1 <= i_s_tvalid;
            if (n_en2) r_v2 <= r_v1;
            if (n_en3) r_v3 <= r_v2;
            if (n_en4) r_v4 <= r_v3;
        end
    end

    // lanes: one per date
    gdd_lane u_lane_first (
        .i_clk     (i_clk),
        .i_ctl     (n_ctl),
        .i_year    (i_s_tdata[13:0]),
        .i_month   (i_s_tdata[17:14]),
        .i_day     (i_s_tdata[22:18]),
        .o_ordinal (w_ord_first)
    );

    gdd_lane u_lane_second (
        .i_clk     (i_clk),
        .i_ctl     (n_ctl),
        .i_year    (i_s_tdata[36:23]),
        .i_month   (i_s_tdata[40:37]),
        .i_day     (i_s_tdata[45:41]),
        .o_ordinal (w_ord_second)
    );

    gdd_merge u_merge (
        .i_clk        (i_clk),
        .i_en         (n_en4),
        .i_ord_first  (w_ord_first),
        .i_ord_second (w_ord_second),
        .o_diff       (w_diff)
    );

    assign o_s_tready = n_en1;
    assign o_m_tvalid = r_v4;
    assign o_m_tdata  = {1'b0, w_diff};

    // checks
    `GDD_ASSERT_ALWAYS(a_empty_after_reset, i_clk, $past(!i_rst_n) |-> !o_m_tvalid)
    `GDD_ASSERT(a_ready_when_out_empty, i_clk, i_rst_n, !o_m_tvalid |-> o_s_tready)
    `GDD_ASSERT(a_no_min_code, i_clk, i_rst_n, o_m_tvalid |-> (o_m_tdata[22:0] != 23'h400000))
    `GDD_ASSERT(a_stage3_moves, i_clk, i_rst_n, (r_v3 && n_en4) |=> r_v4)

endmodule

// ----- tb/sv/gregorian_date_difference_tb.sv -----
// Self-checking testbench for gregorian_date_difference: streams date pairs in,
// predicts each signed day count in SystemVerilog and checks every result.
// Depends on gdd_pkg and the gregorian_date_difference RTL.
`timescale 1ns / 1ps

module gregorian_date_difference_tb;
    import gdd_pkg::*;

    localparam longint SAT_LIMIT   = 64'sd4194303;
    localparam int     STALL_LIMIT = 2000;   // cycles without any item moving
    localparam int     DRAIN_WAIT  = 20;     // well past the pipeline latency
    localparam int     PHASE_ITEMS = 660;

    // input item; first member declared lands in the highest bits
    typedef struct packed {
        logic [DAY_W-1:0]   second_day;
        logic [MONTH_W-1:0] second_month;
        logic [YEAR_W-1:0]  second_year;
        logic [DAY_W-1:0]   first_day;
        logic [MONTH_W-1:0] first_month;
        logic [YEAR_W-1:0]  first_year;
    } t_date_pair;

    // cumulative days before the first of each month, common year
    localparam int MONTH_START [12] = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;

    t_date_pair         pending_pairs [$];
    logic [DIFF_W-1:0]  expected_diffs [$];

    int  tx_idle_pct = 0;
    int  rx_idle_pct = 0;
    bit  hold_tx = 1'b0;
    int  fail_count = 0;
    int  items_sent = 0;
    int  results_checked = 0;
    int  saturated_items = 0;
    int  quiet_cycles = 0;

    gregorian_date_difference u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // day number of a date, day 1 of January of year 0 counting as 1
    function automatic longint day_number(logic [YEAR_W-1:0] y, logic [MONTH_W-1:0] m,
                                          logic [DAY_W-1:0] d);
        longint yy;
        longint leaps;
        longint doy;
        int     mm;
        bit     leap;
        yy = longint'(y);
        mm = int'(m);
        if (mm < 1) mm = 1;
        if (mm > 12) mm = 12;
        leap  = (yy % 400 == 0) || ((yy % 4 == 0) && (yy % 100 != 0));
        leaps = (yy + 3) / 4 - (yy + 99) / 100 + (yy + 399) / 400;
        doy   = MONTH_START[mm-1] + longint'(d) + ((mm > 2 && leap) ? 1 : 0);
        return 365 * yy + leaps + doy;
    endfunction

    // signed days from the first date to the second, clipped to the field
    function automatic logic [DIFF_W-1:0] days_between(t_date_pair p, output bit clipped);
        longint gap;
        gap = day_number(p.second_year, p.second_month, p.second_day)
            - day_number(p.first_year, p.first_month, p.first_day);
        clipped = (gap > SAT_LIMIT) || (gap < -SAT_LIMIT);
        if (gap > SAT_LIMIT) gap = SAT_LIMIT;
        if (gap < -SAT_LIMIT) gap = -SAT_LIMIT;
        return gap[DIFF_W-1:0];
    endfunction

    task automatic flag_error(string what, logic [DIFF_W-1:0] want, logic [DIFF_W-1:0] got);
        fail_count++;
        if (fail_count <= 10)
            $display("%0t: %s: expected %0d, got %0d", $realtime, what,
                     $signed(want), $signed(got));
    endtask

    task automatic add_pair(int y1, int m1, int d1, int y2, int m2, int d2);
        t_date_pair p;
        p.first_year   = y1[YEAR_W-1:0];
        p.first_month  = m1[MONTH_W-1:0];
        p.first_day    = d1[DAY_W-1:0];
        p.second_year  = y2[YEAR_W-1:0];
        p.second_month = m2[MONTH_W-1:0];
        p.second_day   = d2[DAY_W-1:0];
        pending_pairs.push_back(p);
    endtask

    // mostly plausible dates, some close together, some raw bit patterns
    task automatic add_random_pairs(int n);
        int y1;
        for (int i = 0; i < n; i++) begin
            y1 = $urandom_range(9999, 1);
            case ($urandom_range(9))
                0, 1: pending_pairs.push_back(t_date_pair'(46'({$urandom(), $urandom()})));
                2, 3: add_pair(y1, $urandom_range(12, 1), $urandom_range(31, 1),
                               $urandom_range(y1 + 2, (y1 > 2) ? y1 - 2 : 0),
                               $urandom_range(12, 1), $urandom_range(31, 1));
                default: add_pair(y1, $urandom_range(12, 1), $urandom_range(28, 1),
                                  $urandom_range(9999, 1), $urandom_range(12, 1),
                                  $urandom_range(28, 1));
            endcase
        end
    endtask

    // wait until the input queue has gone out and every result is back
    task automatic wait_drained();
        while (pending_pairs.size() != 0 || s_tvalid || expected_diffs.size() != 0)
            @(negedge i_clk);
    endtask

    // sender: presents queued items, predicts each one as it is accepted
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin : take_item
                bit clipped;
                expected_diffs.push_back(days_between(t_date_pair'(s_tdata[45:0]), clipped));
                items_sent++;
                if (clipped) saturated_items++;
            end
            if (!s_tvalid || s_tready) begin
                if (!hold_tx && pending_pairs.size() != 0 &&
                    $urandom_range(99) >= tx_idle_pct) begin
                    s_tdata  <= {2'b00, pending_pairs.pop_front()};
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver: random backpressure, result compared with oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && m_tvalid && m_tready) begin
            if (expected_diffs.size() == 0) begin
                flag_error("result with nothing expected", '0, m_tdata[DIFF_W-1:0]);
            end else begin : check_item
                logic [DIFF_W-1:0] want;
                want = expected_diffs.pop_front();
                results_checked++;
                if (m_tdata[DIFF_W-1:0] !== want)
                    flag_error("day_difference mismatch", want, m_tdata[DIFF_W-1:0]);
            end
        end
        m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // watchdog on cycles in which no item moves on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("timeout: no item moved for %0d cycles", STALL_LIMIT);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: field extremes, leap rules, unchecked days and months, clipping
        add_pair(0, 0, 0, 0, 0, 0);
        add_pair(16383, 15, 31, 16383, 15, 31);
        add_pair(1, 1, 1, 9999, 12, 31);
        add_pair(9999, 12, 31, 1, 1, 1);
        add_pair(2024, 5, 17, 2024, 5, 17);
        add_pair(1900, 2, 28, 1900, 3, 1);
        add_pair(2000, 2, 28, 2000, 3, 1);
        add_pair(2004, 2, 28, 2004, 3, 1);
        add_pair(2100, 2, 28, 2100, 3, 1);
        add_pair(0, 2, 28, 0, 3, 1);
        add_pair(2023, 0, 10, 2023, 1, 10);
        add_pair(2023, 13, 5, 2023, 12, 5);
        add_pair(2023, 15, 31, 2023, 12, 31);
        add_pair(2023, 3, 0, 2023, 2, 28);
        add_pair(2023, 2, 31, 2023, 3, 3);
        add_pair(2023, 1, 31, 2023, 2, 0);
        add_pair(0, 0, 0, 16383, 15, 31);
        add_pair(16383, 15, 31, 0, 0, 0);
        add_pair(1, 1, 1, 12000, 1, 1);
        add_pair(12000, 1, 1, 1, 1, 1);
        add_pair(11484, 1, 1, 0, 1, 1);
        add_pair(2020, 12, 31, 2021, 1, 1);
        add_pair(10922, 7, 21, 5461, 10, 10);

        // light sender gaps, heavy receiver stalls
        @(negedge i_clk);
        tx_idle_pct = 15;
        rx_idle_pct = 77;
        add_random_pairs(PHASE_ITEMS);
        wait_drained();

        // heavy sender gaps, light receiver stalls; sender halts midway until drained
        tx_idle_pct = 77;
        rx_idle_pct = 15;
        add_random_pairs(PHASE_ITEMS);
        while (pending_pairs.size() > PHASE_ITEMS / 2) @(negedge i_clk);
        hold_tx = 1'b1;
        while (s_tvalid || expected_diffs.size() != 0) @(negedge i_clk);
        hold_tx = 1'b0;
        wait_drained();

        // full throughput
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        add_random_pairs(PHASE_ITEMS);
        wait_drained();

        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (expected_diffs.size() != 0) begin
            fail_count++;
            $display("%0d expected results never arrived", expected_diffs.size());
        end

        $display("Sent %0d date pairs (%0d clipped at the field limit), checked %0d results,",
                 items_sent, saturated_items, results_checked);
        $display("under sender-heavy, receiver-heavy and stall-free flow; %0d failures.",
                 fail_count);
        if (fail_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/gdd_pkg.sv
rtl/gdd_lane.sv
rtl/gdd_merge.sv
rtl/gregorian_date_difference.sv
tb/sv/gregorian_date_difference_tb.sv
